// ===== design/ipf_pkg.sv =====
package ipf_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ID_BITS_DEF    = 19;
  localparam int CFG_IDX_BITS   = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TRI_AX = 3'd0,
    REG_TRI_AY = 3'd1,
    REG_TRI_BX = 3'd2,
    REG_TRI_BY = 3'd3,
    REG_TRI_CX = 3'd4,
    REG_TRI_CY = 3'd5
  } cfg_reg_t;

  // Per-stage load enables, driven by the control in the top level.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

// ===== design/ipf_geom.sv =====
module ipf_geom #(
  parameter int COORD_BITS = ipf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  ipf_pkg::pipe_en_t            en,
  input  logic signed [COORD_BITS-1:0] tri_ax,
  input  logic signed [COORD_BITS-1:0] tri_ay,
  input  logic signed [COORD_BITS-1:0] tri_bx,
  input  logic signed [COORD_BITS-1:0] tri_by,
  input  logic signed [COORD_BITS-1:0] tri_cx,
  input  logic signed [COORD_BITS-1:0] tri_cy,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output logic signed [2*COORD_BITS+2:0] len [3],
  output logic signed [2*COORD_BITS+2:0] crs [3]
);

  localparam int D  = COORD_BITS + 1;
  localparam int SW = 2 * D + 1;

  logic signed [COORD_BITS-1:0] vx [3];
  logic signed [COORD_BITS-1:0] vy [3];
  logic signed [D-1:0]          dx_r [3];
  logic signed [D-1:0]          dy_r [3];

  assign vx[0] = tri_ax;
  assign vx[1] = tri_bx;
  assign vx[2] = tri_cx;
  assign vy[0] = tri_ay;
  assign vy[1] = tri_by;
  assign vy[2] = tri_cy;

  for (genvar i = 0; i < 3; i++) begin : g_vert
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    logic signed [D-1:0]   dx_nxt, dy_nxt;
    logic signed [2*D-1:0] sqx, sqy, pxy, pyx;
    logic signed [SW-1:0]  len_nxt, crs_nxt;

    // Vertex relative to the point.
    assign dx_nxt = D'(vx[i]) - D'(px);
    assign dy_nxt = D'(vy[i]) - D'(py);

    always_ff @(posedge clk) begin
      if (en.s1) begin
        dx_r[i] <= dx_nxt;
        dy_r[i] <= dy_nxt;
      end
    end

    // Squared length of this vertex and the cross product of the other two.
    // The cross terms are ordered so that all three determinant terms add.
    assign sqx     = dx_r[i] * dx_r[i];
    assign sqy     = dy_r[i] * dy_r[i];
    assign pxy     = dx_r[J] * dy_r[K];
    assign pyx     = dx_r[K] * dy_r[J];
    assign len_nxt = SW'(sqx) + SW'(sqy);
    assign crs_nxt = SW'(pxy) - SW'(pyx);

    always_ff @(posedge clk) begin
      if (en.s2) begin
        len[i] <= len_nxt;
        crs[i] <= crs_nxt;
      end
    end
  end

endmodule

// ===== design/ipf_mulacc.sv =====
module ipf_mulacc #(
  parameter int COORD_BITS = ipf_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  ipf_pkg::pipe_en_t              en,
  input  logic signed [2*COORD_BITS+2:0] len [3],
  input  logic signed [2*COORD_BITS+2:0] crs [3],
  output logic                           pos_r
);

  localparam int H  = COORD_BITS + 1;
  localparam int PW = 2 * H + 2;
  localparam int DW = 4 * H + 4;

  logic signed [PW-1:0]  pp_hh_r [3];
  logic signed [PW-1:0]  pp_lh_r [3];
  logic        [2*H-1:0] pp_hl_r [3];
  logic        [2*H-1:0] pp_ll_r [3];
  logic        [DW-1:0]  term_r  [3];
  logic        [DW-1:0]  det;
  logic                  pos_nxt;

  for (genvar i = 0; i < 3; i++) begin : g_term
    logic        [H-1:0] lh, ll, xl;
    logic signed [H:0]   xh, lhs, lls;
    logic        [DW-1:0] hh_ext, lh_ext, hl_ext, ll_ext, term_nxt;

    // The squared length is never negative and fits in 2H bits, so it splits
    // into two unsigned halves; the cross product splits into a signed high
    // part and an unsigned low part.
    assign lh  = len[i][2*H-1:H];
    assign ll  = len[i][H-1:0];
    assign xl  = crs[i][H-1:0];
    assign xh  = crs[i][2*H:H];
    assign lhs = {1'b0, lh};
    assign lls = {1'b0, ll};

    always_ff @(posedge clk) begin
      if (en.s3) begin
        pp_hh_r[i] <= lhs * xh;
        pp_lh_r[i] <= lls * xh;
        pp_hl_r[i] <= lh * xl;
        pp_ll_r[i] <= ll * xl;
      end
    end

    assign hh_ext   = DW'(pp_hh_r[i]);
    assign lh_ext   = DW'(pp_lh_r[i]);
    assign hl_ext   = DW'(pp_hl_r[i]);
    assign ll_ext   = DW'(pp_ll_r[i]);
    assign term_nxt = (hh_ext << (2 * H)) + ((hl_ext + lh_ext) << H) + ll_ext;

    always_ff @(posedge clk) begin
      if (en.s4) begin
        term_r[i] <= term_nxt;
      end
    end
  end

  assign det     = term_r[0] + term_r[1] + term_r[2];
  assign pos_nxt = !det[DW-1] && (|det);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== design/incircle_point_filter.sv =====
// Tests a stream of points against the circumcircle of the triangle held in
// the six configuration registers, using the exact in-circle determinant on
// coordinates taken relative to the point; an alive point is kept only when
// the determinant is strictly positive, so a clockwise triangle keeps the
// points outside instead. The block takes one word per cycle while the output
// is not stalled and passes it through five register stages: differences,
// squares and cross products, split partial products of the final multiply,
// their recombination, and the three-way sum with its sign test. Each stage
// moves on as soon as the one after it has room, so bubbles close up while
// the output is stalled. Write the registers only while no word is in flight.
module incircle_point_filter #(
  parameter int COORD_BITS = ipf_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = ipf_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ipf_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [COORD_BITS-1:0]            cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     in_point_x,
  input  logic signed [COORD_BITS-1:0]     in_point_y,
  input  logic [ID_BITS-1:0]               in_point_id,
  input  logic                             in_point_alive,
  input  logic                             in_last_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ID_BITS-1:0]               out_id,
  output logic                             out_keep,
  output logic                             out_last
);

  localparam int NSTG = 5;
  localparam int SW   = 2 * COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] tri_ax_r, tri_ay_r, tri_bx_r, tri_by_r, tri_cx_r, tri_cy_r;
  logic [NSTG-1:0]              v_r;
  logic [NSTG-1:0]              rdy;
  ipf_pkg::pipe_en_t            en;
  logic [ID_BITS-1:0]           id_r    [NSTG];
  logic                         alive_r [NSTG];
  logic                         last_r  [NSTG];
  logic signed [SW-1:0]         len [3];
  logic signed [SW-1:0]         crs [3];
  logic                         pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_ax_r <= '0;
      tri_ay_r <= '0;
      tri_bx_r <= '0;
      tri_by_r <= '0;
      tri_cx_r <= '0;
      tri_cy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ipf_pkg::REG_TRI_AX: tri_ax_r <= cfg_data;
        ipf_pkg::REG_TRI_AY: tri_ay_r <= cfg_data;
        ipf_pkg::REG_TRI_BX: tri_bx_r <= cfg_data;
        ipf_pkg::REG_TRI_BY: tri_by_r <= cfg_data;
        ipf_pkg::REG_TRI_CX: tri_cx_r <= cfg_data;
        ipf_pkg::REG_TRI_CY: tri_cy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its word moves on this cycle.
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign en.s1    = rdy[0];
  assign en.s2    = rdy[1];
  assign en.s3    = rdy[2];
  assign en.s4    = rdy[3];
  assign en.s5    = rdy[4];
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      id_r[0]    <= in_point_id;
      alive_r[0] <= in_point_alive;
      last_r[0]  <= in_last_point;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        id_r[k]    <= id_r[k-1];
        alive_r[k] <= alive_r[k-1];
        last_r[k]  <= last_r[k-1];
      end
    end
  end

  ipf_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk    (clk),
    .en     (en),
    .tri_ax (tri_ax_r),
    .tri_ay (tri_ay_r),
    .tri_bx (tri_bx_r),
    .tri_by (tri_by_r),
    .tri_cx (tri_cx_r),
    .tri_cy (tri_cy_r),
    .px     (in_point_x),
    .py     (in_point_y),
    .len    (len),
    .crs    (crs)
  );

  ipf_mulacc #(
    .COORD_BITS(COORD_BITS)
  ) u_mulacc (
    .clk   (clk),
    .en    (en),
    .len   (len),
    .crs   (crs),
    .pos_r (pos_r)
  );

  assign out_valid = v_r[NSTG-1];
  assign out_id    = id_r[NSTG-1];
  assign out_keep  = alive_r[NSTG-1] && pos_r;
  assign out_last  = last_r[NSTG-1];

`ifndef ASSERT_OFF
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output drains");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty stage in the pipeline");

  a_last_hop: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-2] && en.s5 |=> out_valid)
    else $error("word lost between the last two stages");
`endif

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = ipf_pkg::COORD_BITS_DEF;
  localparam int ID_BITS    = ipf_pkg::ID_BITS_DEF;
  localparam int ID_MAX     = (1 << ID_BITS) - 1;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [ipf_pkg::CFG_IDX_BITS-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [ipf_pkg::CFG_IDX_BITS-1:0] SPARE_IDX_HI = 3'd7;

  localparam int RANDOM_PHASES   = 8;
  localparam int POINTS_PER_SET  = 200;
  localparam int SETTLE_CYCLES   = 10;
  localparam int LONG_HOLD       = 80;
  localparam int QUIET_LIMIT     = 1000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t             x;
    coord_t             y;
    logic [ID_BITS-1:0] id;
    logic               alive;
    logic               last;
  } point_t;

  typedef struct {
    logic [ID_BITS-1:0] id;
    logic               keep;
    logic               last;
  } verdict_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [ipf_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [COORD_BITS-1:0]            cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  coord_t                           in_point_x = '0;
  coord_t                           in_point_y = '0;
  logic [ID_BITS-1:0]               in_point_id = '0;
  logic                             in_point_alive = 1'b0;
  logic                             in_last_point = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [ID_BITS-1:0]               out_id;
  logic                             out_keep;
  logic                             out_last;

  incircle_point_filter #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_id   (in_point_id),
    .in_point_alive(in_point_alive),
    .in_last_point (in_last_point),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_id        (out_id),
    .out_keep      (out_keep),
    .out_last      (out_last)
  );

  // Triangle as the block should hold it.
  coord_t vtx_x [3];
  coord_t vtx_y [3];

  point_t   point_queue[$];
  verdict_t verdict_queue[$];

  logic allow_idle = 1'b1;
  logic in_word_taken = 1'b0;
  int   send_gap = 0;
  int   stall_gap = 0;
  int   hold_left = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   quiet_cycles = 0;
  int   error_count = 0;
  int   points_checked = 0;
  int   kept_count = 0;
  int   triangle_count = 0;
  int   near_x = 0;
  int   near_y = 0;
  int   spread = 1;

  initial begin
    forever #5 clk = ~clk;
  end

  // Exact in-circle determinant on coordinates relative to the point; 128 bits
  // leave plenty of headroom for 16-bit inputs.
  function automatic logic in_circumcircle(coord_t px, coord_t py);
    logic signed [127:0] dx [3];
    logic signed [127:0] dy [3];
    logic signed [127:0] lift [3];
    logic signed [127:0] cross_bc, cross_ac, cross_ab, det;
    int k;
    for (k = 0; k < 3; k++) begin
      dx[k] = vtx_x[k] - px;
      dy[k] = vtx_y[k] - py;
      lift[k] = dx[k] * dx[k] + dy[k] * dy[k];
    end
    cross_bc = dx[1] * dy[2] - dx[2] * dy[1];
    cross_ac = dx[0] * dy[2] - dx[2] * dy[0];
    cross_ab = dx[0] * dy[1] - dx[1] * dy[0];
    det = lift[0] * cross_bc - lift[1] * cross_ac + lift[2] * cross_ab;
    return det > 0;
  endfunction

  function automatic verdict_t predict_verdict(point_t p);
    verdict_t v;
    v.id   = p.id;
    v.keep = p.alive && in_circumcircle(p.x, p.y);
    v.last = p.last;
    return v;
  endfunction

  function automatic coord_t to_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_offset(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic void queue_point(int x, int y, int id, logic alive, logic last);
    point_t p;
    p.x     = to_coord(x);
    p.y     = to_coord(y);
    p.id    = id[ID_BITS-1:0];
    p.alive = alive;
    p.last  = last;
    point_queue.push_back(p);
  endfunction

  // Wait until every queued word has gone in and every verdict has come back.
  task automatic settle();
    while (point_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ipf_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [COORD_BITS-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      ipf_pkg::REG_TRI_AX: vtx_x[0] = data;
      ipf_pkg::REG_TRI_AY: vtx_y[0] = data;
      ipf_pkg::REG_TRI_BX: vtx_x[1] = data;
      ipf_pkg::REG_TRI_BY: vtx_y[1] = data;
      ipf_pkg::REG_TRI_CX: vtx_x[2] = data;
      ipf_pkg::REG_TRI_CY: vtx_y[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_triangle(input int ax, input int ay, input int bx, input int by,
                              input int cx, input int cy);
    settle();
    write_reg(ipf_pkg::REG_TRI_AX, to_coord(ax));
    write_reg(ipf_pkg::REG_TRI_AY, to_coord(ay));
    write_reg(ipf_pkg::REG_TRI_BX, to_coord(bx));
    write_reg(ipf_pkg::REG_TRI_BY, to_coord(by));
    write_reg(ipf_pkg::REG_TRI_CX, to_coord(cx));
    write_reg(ipf_pkg::REG_TRI_CY, to_coord(cy));
    triangle_count++;
  endtask

  // Either a full-range triangle that favors the extremes, or one of a
  // random size around a random center, so points land on both sides.
  task automatic pick_random_triangle();
    int mode;
    int k;
    int v [6];
    mode = $urandom_range(0, 3);
    if (mode == 0) begin
      spread = 65536;
      near_x = 0;
      near_y = 0;
      for (k = 0; k < 6; k++) begin
        case ($urandom_range(0, 5))
          0: v[k] = -32768;
          1: v[k] = 32767;
          default: v[k] = rand16();
        endcase
      end
    end else begin
      spread = (mode == 1) ? 40 : (mode == 2) ? 2000 : 12000;
      near_x = rand_offset(20000);
      near_y = rand_offset(20000);
      for (k = 0; k < 6; k++)
        v[k] = ((k % 2) == 0 ? near_x : near_y) + rand_offset(spread);
    end
    set_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic queue_random_point(input logic last);
    int sel, k, x, y, id;
    sel = $urandom_range(0, 9);
    k = $urandom_range(0, 2);
    if (sel == 0) begin
      // A vertex itself lies exactly on the circle.
      x = vtx_x[k];
      y = vtx_y[k];
    end else if (sel <= 2) begin
      x = rand16();
      y = rand16();
    end else begin
      x = near_x + rand_offset(2 * spread);
      y = near_y + rand_offset(2 * spread);
    end
    case ($urandom_range(0, 15))
      0: id = 0;
      1: id = ID_MAX;
      default: id = $urandom_range(0, ID_MAX);
    endcase
    queue_point(x, y, id, $urandom_range(0, 3) != 0, last);
  endtask

  // Sender: a word is held until taken, then the next one or an idle burst.
  always @(negedge clk) begin
    point_t next_point;
    logic offer;
    if (!in_valid || in_word_taken) begin
      offer = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (allow_idle && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 6);
      end else if (point_queue.size() != 0) begin
        next_point = point_queue.pop_front();
        offer = 1'b1;
        in_point_x     <= next_point.x;
        in_point_y     <= next_point.y;
        in_point_id    <= next_point.id;
        in_point_alive <= next_point.alive;
        in_last_point  <= next_point.last;
      end
      in_valid <= offer;
    end
  end

  // Receiver: random stall bursts plus long holds on request.
  always @(negedge clk) begin
    logic stall_next;
    if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      stall_next = 1'b1;
    end else if (allow_idle && $urandom_range(0, 9) == 0) begin
      stall_gap = $urandom_range(0, 6);
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
    end
    out_stall <= stall_next;
  end

  // Predict on each accepted point, check each accepted verdict.
  always @(posedge clk) begin
    point_t   taken;
    verdict_t want;
    in_word_taken = rst_n && in_valid && !in_stall;
    if (in_word_taken) begin
      taken.x     = in_point_x;
      taken.y     = in_point_y;
      taken.id    = in_point_id;
      taken.alive = in_point_alive;
      taken.last  = in_last_point;
      verdict_queue.push_back(predict_verdict(taken));
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (verdict_queue.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none, got id %0d keep %0b last %0b",
                 $time, out_id, out_keep, out_last);
      end else begin
        want = verdict_queue.pop_front();
        points_checked++;
        if (out_keep === 1'b1) kept_count++;
        if (out_id !== want.id) begin
          error_count++;
          $display("%0t: out_id expected %0d, got %0d", $time, want.id, out_id);
        end
        if (out_keep !== want.keep) begin
          error_count++;
          $display("%0t: out_keep for id %0d expected %0b, got %0b",
                   $time, want.id, want.keep, out_keep);
        end
        if (out_last !== want.last) begin
          error_count++;
          $display("%0t: out_last for id %0d expected %0b, got %0b",
                   $time, want.id, want.last, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d verdicts outstanding",
               $time, QUIET_LIMIT, verdict_queue.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int phase, n;
    for (n = 0; n < 3; n++) begin
      vtx_x[n] = '0;
      vtx_y[n] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // All vertices reset to the origin: determinant is zero, nothing kept.
    queue_point(100, -7, 5, 1'b1, 1'b0);
    queue_point(-32768, 32767, ID_MAX, 1'b1, 1'b1);

    // Counterclockwise triangle; circumcenter (0,-250), radius 1250.
    set_triangle(-1000, -1000, 1000, -1000, 0, 1000);
    write_reg(SPARE_IDX_LO, 16'h7fff);
    write_reg(SPARE_IDX_HI, 16'h8000);
    queue_point(0, 0, 1, 1'b1, 1'b0);
    queue_point(0, 0, 2, 1'b0, 1'b0);
    queue_point(-1000, -1000, 3, 1'b1, 1'b0);
    queue_point(0, -1500, 4, 1'b1, 1'b0);
    queue_point(0, -1499, 0, 1'b1, 1'b0);
    queue_point(0, -1501, ID_MAX, 1'b1, 1'b0);
    queue_point(32767, 32767, 6, 1'b1, 1'b0);
    queue_point(-32768, -32768, 7, 1'b1, 1'b0);
    queue_point(32767, -32768, 8, 1'b0, 1'b1);

    // Same triangle wound clockwise: the outside is kept instead.
    set_triangle(-1000, -1000, 0, 1000, 1000, -1000);
    queue_point(0, 0, 9, 1'b1, 1'b0);
    queue_point(32767, 32767, 10, 1'b1, 1'b0);
    queue_point(0, -1501, 11, 1'b1, 1'b1);

    // Right triangle at the coordinate limits; the fourth rectangle corner
    // sits on its circumcircle.
    set_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
    queue_point(0, 0, 12, 1'b1, 1'b0);
    queue_point(32767, 32767, 13, 1'b1, 1'b0);
    queue_point(-32768, -32768, 14, 1'b1, 1'b0);
    queue_point(-32768, 32767, 15, 1'b0, 1'b1);

    // Collinear vertices.
    set_triangle(0, 0, 1, 1, 2, 2);
    queue_point(5, -3, 16, 1'b1, 1'b0);
    queue_point(-3, 5, 17, 1'b1, 1'b1);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_random_triangle();
      if (($urandom_range(0, 3)) == 0)
        write_reg($urandom_range(0, 1) ? SPARE_IDX_LO : SPARE_IDX_HI,
                  COORD_BITS'($urandom));
      // The last two sets run without idling on either side.
      allow_idle = (phase < RANDOM_PHASES - 2);
      for (n = 0; n < POINTS_PER_SET; n++) begin
        if (phase == 3 && n == POINTS_PER_SET / 2)
          settle();
        queue_random_point(n == POINTS_PER_SET - 1 || $urandom_range(0, 15) == 0);
      end
      // The output holds off while a full set is still being offered.
      if (phase == 2)
        hold_requests++;
    end

    settle();
    $display("Checked %0d points against %0d triangles, %0d kept; included a long",
             points_checked, triangle_count, kept_count);
    $display("output hold, a drained pause and stretches without idling.");
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ipf_pkg.sv
design/ipf_geom.sv
design/ipf_mulacc.sv
design/incircle_point_filter.sv
test/tb_top.sv
